// File: rtl/core/multi_channel_pulse_output_top_macros.svh
// Assertion macros shared by the pulse output RTL.
`ifndef MULTI_CHANNEL_PULSE_OUTPUT_TOP_MACROS_SVH
`define MULTI_CHANNEL_PULSE_OUTPUT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MCPO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define MCPO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mcpo_pkg.sv
// Types, constants and the pulse length table of the pulse output block.
`timescale 1ns / 1ps
package mcpo_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int CH_W             = 3;
	localparam int MODE_W           = 4;
	localparam int LEVELS_W         = 8;
	localparam int CNT_W            = 9;

	// Opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_HIGH        = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PULSE_FIRST = 4'd2;
	localparam logic [MODE_W-1:0] MODE_PULSE_LAST  = 4'd9;

	localparam logic [CNT_W-1:0] PULSE_MAX = 9'd400;

	// Channel phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RUN  = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	// Per-channel control for one word
	typedef struct packed {
		logic              tick;
		logic              wr;
		logic [MODE_W-1:0] mode;
	} chan_ctl_t;

	// Pulse length in ticks, indexed by mode minus two
	function automatic logic [CNT_W-1:0] pulse_len(input logic [2:0] idx);
		logic [CNT_W-1:0] len;
		unique case (idx)
			3'd0: len = 9'd10;
			3'd1: len = 9'd20;
			3'd2: len = 9'd50;
			3'd3: len = 9'd80;
			3'd4: len = 9'd100;
			3'd5: len = 9'd150;
			3'd6: len = 9'd200;
			3'd7: len = 9'd400;
			default: len = 9'd400;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/core/mcpo_chan.sv
// One output channel: pending mode, applied mode, pulse phase and counter.
`timescale 1ns / 1ps
`include "multi_channel_pulse_output_top_macros.svh"
module mcpo_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  mcpo_pkg::chan_ctl_t ctl,
	output logic                level,
	output logic                level_nxt
);
	import mcpo_pkg::*;

	phase_t            phase_q, phase_n;
	logic [MODE_W-1:0] amode_q, amode_n;
	logic [MODE_W-1:0] pmode_q, pmode_n;
	logic              pflag_q, pflag_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              level_q, level_n;
	logic              take;
	logic [CNT_W-1:0]  len;

	// Next state for a mode write or a tick
	always_comb begin
		phase_n = phase_q;
		amode_n = amode_q;
		pmode_n = pmode_q;
		pflag_n = pflag_q;
		cnt_n   = cnt_q;
		level_n = level_q;
		take    = ((phase_q == PH_IDLE) || (phase_q == PH_DONE)) && pflag_q;
		len     = '0;
		if (ctl.wr) begin
			pmode_n = ctl.mode;
			pflag_n = 1'b1;
		end else if (ctl.tick) begin
			// idle or finished: pick up the pending mode
			if (take) begin
				amode_n = pmode_q;
				pflag_n = 1'b0;
				phase_n = PH_IDLE;
				cnt_n   = '0;
			end
			len = pulse_len(amode_n[2:0] - 3'd2);
			if (amode_n <= MODE_HIGH) begin
				if (phase_n == PH_IDLE) begin
					level_n = amode_n[0];
					phase_n = PH_DONE;
				end
			end else if (amode_n <= MODE_PULSE_LAST) begin
				if (phase_n == PH_IDLE) begin
					level_n = 1'b1;
					phase_n = PH_RUN;
				end
				// old count against the length, then count up
				if (phase_n == PH_RUN) begin
					if (cnt_n >= len) begin
						level_n = 1'b0;
						phase_n = PH_DONE;
					end
					cnt_n = cnt_n + 9'd1;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			amode_q <= '0;
			pmode_q <= '0;
			pflag_q <= 1'b0;
			cnt_q   <= '0;
			level_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			amode_q <= amode_n;
			pmode_q <= pmode_n;
			pflag_q <= pflag_n;
			cnt_q   <= cnt_n;
			level_q <= level_n;
		end
	end

	assign level     = level_q;
	assign level_nxt = level_n;

	`MCPO_ASSERT_IMP(a_run_is_pulse, phase_q == PH_RUN, amode_q >= MODE_PULSE_FIRST && amode_q <= MODE_PULSE_LAST, "running phase without a pulse mode")
	`MCPO_ASSERT_IMP(a_run_cnt_bound, phase_q == PH_RUN, cnt_q <= PULSE_MAX, "pulse counter past longest pulse")
	`MCPO_ASSERT_IMP(a_done_pulse_low, phase_q == PH_DONE && amode_q >= MODE_PULSE_FIRST && amode_q <= MODE_PULSE_LAST, !level_q, "finished pulse left output high")

endmodule

// File: rtl/core/multi_channel_pulse_output_top.sv
// Top level of the pulse output bank: input register, channels, result register.
`timescale 1ns / 1ps
`include "multi_channel_pulse_output_top_macros.svh"
// Pulse output bank.
// Input channel (item_valid / item_stall) carries one word: opcode 0 is a
// tick that steps every channel, opcode 1 stores new_mode as the pending
// mode of the addressed channel. Writes to channels at or above
// NUM_CHANNELS are dropped. Each word yields one result word on the
// result channel (result_valid / result_stall): levels, bit i the output
// of channel i after the word, zero above the last channel.
// A word accepted into the input register moves on once the result slot
// is free: all channels update and the result register loads at that
// same edge, and the result is then offered from the result register.
// Throughput: one word per cycle unless the receiver stalls, set by the
// single channel update stage between input register and result register.
// When the receiver stalls, the result holds; one more word may still
// enter the input register, after which item_stall rises.
// Reset clears every channel to mode 0, not started, output low, no
// pending mode, and empties both registers.
module multi_channel_pulse_output_top #(
	parameter int NUM_CHANNELS = mcpo_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          opcode,
	input  logic [mcpo_pkg::CH_W-1:0]     channel,
	input  logic [mcpo_pkg::MODE_W-1:0]   new_mode,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mcpo_pkg::LEVELS_W-1:0] levels
);
	import mcpo_pkg::*;

	logic                valid_s1;
	logic                op_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [MODE_W-1:0]   mode_s1;
	logic                accept;
	logic                adv;
	logic                result_valid_q;
	logic [LEVELS_W-1:0] levels_q;
	logic [NUM_CHANNELS-1:0] lvl_cur;
	logic [NUM_CHANNELS-1:0] lvl_nxt;
	logic [LEVELS_W-1:0] lvl_byte_cur;
	logic [LEVELS_W-1:0] lvl_byte_nxt;

	// Handshake: input register drains whenever the result slot frees up
	assign adv        = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			ch_s1   <= channel;
			mode_s1 <= new_mode;
		end
	end

	// Channel lanes
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		chan_ctl_t ctl;
		logic      hit;
		if (i < (1 << CH_W)) begin : g_addr
			assign hit = (ch_s1 == CH_W'(i));
		end else begin : g_noaddr
			assign hit = 1'b0;
		end
		assign ctl.tick = adv && (op_s1 == OP_TICK);
		assign ctl.wr   = adv && (op_s1 == OP_WRITE) && hit;
		assign ctl.mode = mode_s1;

		mcpo_chan u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.level     (lvl_cur[i]),
			.level_nxt (lvl_nxt[i])
		);
	end

	// Map channels onto the levels field
	for (genvar j = 0; j < LEVELS_W; j++) begin : g_byte
		if (j < NUM_CHANNELS) begin : g_on
			assign lvl_byte_cur[j] = lvl_cur[j];
			assign lvl_byte_nxt[j] = lvl_nxt[j];
		end else begin : g_off
			assign lvl_byte_cur[j] = 1'b0;
			assign lvl_byte_nxt[j] = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			levels_q <= lvl_byte_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign levels       = levels_q;

	`MCPO_ASSERT_IMP(a_stall_only_full, item_stall, valid_s1 && result_valid_q, "input stalled with a free slot")
	`MCPO_ASSERT_NXT(a_adv_loads_result, adv, result_valid_q, "advanced word did not reach result register")
	`MCPO_ASSERT_NXT(a_write_keeps_levels, adv && op_s1 == OP_WRITE, levels_q == $past(lvl_byte_cur), "mode write changed the levels")

endmodule

// File: test/tb_multi_channel_pulse_output_top.sv
// Testbench for the pulse output bank: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps
module tb_multi_channel_pulse_output_top;
	import mcpo_pkg::*;

	localparam int N_CH = NUM_CHANNELS_DEF;

	// Mode codes without a package name
	localparam logic [MODE_W-1:0] MODE_LOW      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_NOP_FIRST = 4'd10;
	localparam logic [MODE_W-1:0] MODE_NOP_LAST  = 4'd15;

	// Pulse width in ticks per pulse mode, first pulse mode first
	localparam logic [CNT_W-1:0] PULSE_TICKS [8] = '{
		9'd10, 9'd20, 9'd50, 9'd80, 9'd100, 9'd150, 9'd200, 9'd400
	};

	localparam int RAND_PER_PHASE = 567;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct {
		logic                op;
		logic [CH_W-1:0]     ch;
		logic [MODE_W-1:0]   md;
		logic                known;
		logic [LEVELS_W-1:0] lv;
	} dir_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic                opcode = OP_TICK;
	logic [CH_W-1:0]     channel = '0;
	logic [MODE_W-1:0]   new_mode = MODE_LOW;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [LEVELS_W-1:0] levels;

	// Predicted channel state
	phase_t            ch_phase  [N_CH];
	logic [MODE_W-1:0] ch_mode   [N_CH];
	logic [MODE_W-1:0] ch_pend   [N_CH];
	logic              ch_pend_f [N_CH];
	logic [CNT_W-1:0]  ch_ticks  [N_CH];
	logic              ch_level  [N_CH];

	logic [LEVELS_W-1:0] levels_due [$];
	logic [LEVELS_W-1:0] lv_exp;
	int                  mismatch_count = 0;
	int                  send_gap_pct = 0;
	int                  recv_stall_pct = 0;

	// Directed words: reset state, hold modes, pulse with a write during it,
	// no-action modes, overwrite before a tick, field extremes, pulse end
	dir_word_t dir_words [24] = '{
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h00},
		'{OP_WRITE, 3'd0, MODE_HIGH,        1'b1, 8'h00},
		'{OP_TICK,  3'd7, MODE_NOP_LAST,    1'b1, 8'h01},
		'{OP_WRITE, 3'd7, MODE_HIGH,        1'b1, 8'h01},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h81},
		'{OP_WRITE, 3'd3, MODE_PULSE_FIRST, 1'b1, 8'h81},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h89},
		'{OP_WRITE, 3'd3, MODE_LOW,         1'b1, 8'h89},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h89},
		'{OP_WRITE, 3'd5, MODE_NOP_LAST,    1'b1, 8'h89},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h89},
		'{OP_WRITE, 3'd5, MODE_NOP_FIRST,   1'b1, 8'h89},
		'{OP_WRITE, 3'd5, MODE_HIGH,        1'b1, 8'h89},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'ha9},
		'{OP_WRITE, 3'd7, MODE_LOW,         1'b1, 8'ha9},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b1, 8'h29},
		'{OP_WRITE, 3'd6, MODE_PULSE_LAST,  1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00},
		'{OP_WRITE, 3'd0, MODE_NOP_FIRST,   1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00},
		'{OP_TICK,  3'd0, MODE_LOW,         1'b0, 8'h00}
	};

	multi_channel_pulse_output_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.channel      (channel),
		.new_mode     (new_mode),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.levels       (levels)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clear the predicted bank to its reset state
	function automatic void bank_clear();
		for (int c = 0; c < N_CH; c++) begin
			ch_phase[c]  = PH_IDLE;
			ch_mode[c]   = MODE_LOW;
			ch_pend[c]   = MODE_LOW;
			ch_pend_f[c] = 1'b0;
			ch_ticks[c]  = '0;
			ch_level[c]  = 1'b0;
		end
	endfunction

	// Step one channel by one tick
	function automatic void channel_tick(input int c);
		logic [CNT_W-1:0] width;
		logic [CNT_W-1:0] prev;
		logic [2:0]       idx;
		// idle or finished channels take their pending mode
		if ((ch_phase[c] == PH_IDLE || ch_phase[c] == PH_DONE) && ch_pend_f[c]) begin
			ch_mode[c]   = ch_pend[c];
			ch_pend_f[c] = 1'b0;
			ch_phase[c]  = PH_IDLE;
			ch_ticks[c]  = '0;
		end
		if (ch_mode[c] == MODE_LOW || ch_mode[c] == MODE_HIGH) begin
			if (ch_phase[c] == PH_IDLE) begin
				ch_level[c] = (ch_mode[c] == MODE_HIGH);
				ch_phase[c] = PH_DONE;
			end
		end else if (ch_mode[c] <= MODE_PULSE_LAST) begin
			idx   = 3'(ch_mode[c] - MODE_PULSE_FIRST);
			width = PULSE_TICKS[idx];
			if (ch_phase[c] == PH_IDLE) begin
				ch_level[c] = 1'b1;
				ch_phase[c] = PH_RUN;
			end
			if (ch_phase[c] == PH_RUN) begin
				prev        = ch_ticks[c];
				ch_ticks[c] = prev + 1'b1;
				if (prev >= width) begin
					ch_level[c] = 1'b0;
					ch_phase[c] = PH_DONE;
				end
			end
		end
		// no-action modes hold the level and leave the phase idle
	endfunction

	// Apply one word to the predicted bank and return the output levels
	function automatic logic [LEVELS_W-1:0] bank_apply_word(input logic op,
			input logic [CH_W-1:0] ch, input logic [MODE_W-1:0] md);
		logic [LEVELS_W-1:0] lv;
		lv = '0;
		if (op == OP_TICK) begin
			for (int c = 0; c < N_CH; c++)
				channel_tick(c);
		end else if (int'(ch) < N_CH) begin
			ch_pend[ch]   = md;
			ch_pend_f[ch] = 1'b1;
		end
		for (int c = 0; c < N_CH && c < LEVELS_W; c++)
			lv[c] = ch_level[c];
		return lv;
	endfunction

	// Offer one word after a random gap; record the expected levels on acceptance
	task automatic send_word(input logic op, input logic [CH_W-1:0] ch,
			input logic [MODE_W-1:0] md, input logic known, input logic [LEVELS_W-1:0] lv);
		logic [LEVELS_W-1:0] lv_pred;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		channel    <= ch;
		new_mode   <= md;
		do
			@(posedge clk);
		while (item_stall);
		lv_pred = bank_apply_word(op, ch, md);
		levels_due.push_back(known ? lv : lv_pred);
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic hold_until_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
	endtask

	// Random words: mostly ticks, writes weighted toward short pulses
	task automatic run_random(input int count);
		logic              op;
		logic [CH_W-1:0]   ch;
		logic [MODE_W-1:0] md;
		int                r;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(99) < 72) ? OP_TICK : OP_WRITE;
			ch = CH_W'($urandom_range(N_CH - 1));
			r  = $urandom_range(99);
			if (r < 12)
				md = $urandom_range(1) ? MODE_HIGH : MODE_LOW;
			else if (r < 80)
				md = MODE_PULSE_FIRST + MODE_W'($urandom_range(3));
			else if (r < 88)
				md = MODE_PULSE_FIRST + MODE_W'(4 + $urandom_range(2));
			else if (r < 91)
				md = MODE_PULSE_LAST;
			else
				md = MODE_W'($urandom_range(MODE_NOP_LAST, MODE_NOP_FIRST));
			send_word(op, ch, md, 1'b0, '0);
		end
	endtask

	// Receiver stalls at random
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (levels_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got levels %02h", $time, levels);
				mismatch_count++;
			end else begin
				lv_exp = levels_due.pop_front();
				if (levels !== lv_exp) begin
					$display("%0t: levels mismatch, expected %02h, got %02h",
						$time, lv_exp, levels);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		bank_clear();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver stalls often
		send_gap_pct   = 24;
		recv_stall_pct = 65;
		foreach (dir_words[i])
			send_word(dir_words[i].op, dir_words[i].ch, dir_words[i].md,
				dir_words[i].known, dir_words[i].lv);
		run_random(RAND_PER_PHASE);
		hold_until_drained();

		// roles swapped
		send_gap_pct   = 65;
		recv_stall_pct = 24;
		run_random(RAND_PER_PHASE);
		hold_until_drained();

		// full rate both sides
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_random(RAND_PER_PHASE);
		hold_until_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_multi_channel_pulse_output_top: PASS");
		else
			$display("tb_multi_channel_pulse_output_top: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb_multi_channel_pulse_output_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mcpo_pkg.sv
rtl/core/mcpo_chan.sv
rtl/core/multi_channel_pulse_output_top.sv
test/tb_multi_channel_pulse_output_top.sv
